// ===== rtl/core/gha_pkg.sv =====
// Shared constants, types and op codes for the generational handle allocator.
package gha_pkg;
  localparam int SLOTS = 256;
  localparam int GEN_BITS = 16;
  localparam int ID_W = $clog2(SLOTS);
  localparam int CNT_W = ID_W + 1;

  localparam logic [2:0] OP_RESERVE = 3'd0;
  localparam logic [2:0] OP_MATERIALIZE = 3'd1;
  localparam logic [2:0] OP_DISCARD = 3'd2;
  localparam logic [2:0] OP_DESTROY = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_FREE = 2'd1;
  localparam logic [1:0] ST_RESERVED = 2'd2;
  localparam logic [1:0] ST_ALIVE = 2'd3;

  // slot table entry: state plus generation
  localparam int SLOT_W = 2 + GEN_BITS;
  // alive list entry: position-of-slot is kept separately; entry holds id and gen
  localparam int ALIVE_W = ID_W + GEN_BITS;

  typedef struct packed {
    logic       ok;
    logic [1:0] status;
    logic [7:0] new_id;
    logic [15:0] new_gen;
    logic       full_res;
    logic [8:0] alive_total;
  } result_t;
endpackage

// ===== rtl/core/gha_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/generational_handle_allocator.sv =====
// Top level of the generational handle allocator.
// One command is taken when start is high and busy is low; its result shows
// on the out_ ports for one cycle with out_valid, and cannot be held off.
// A command's result follows the reads of the slot table and free stack and
// an evaluate step; a reserve that pops the free stack also reads the popped
// slot's generation, and destroy also reads the alive position, the list
// entry at it and the last entry, then checks and writes back. busy stays high
// through the result cycle, so the next command is taken only after it. The
// memories have registered reads and are read, checked and written back in
// sequence. No clearing pass is needed: entries are only read below the fill
// counts.
module generational_handle_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic signed [8:0] in_handle_id,
  input  logic [15:0] in_handle_gen,
  output logic        out_valid,
  output logic        out_ok,
  output logic [1:0]  out_status,
  output logic [7:0]  out_new_id,
  output logic [15:0] out_new_gen,
  output logic        out_full_res,
  output logic [8:0]  out_alive_total
);
  localparam int IW = gha_pkg::ID_W;
  localparam int CW = gha_pkg::CNT_W;
  localparam int GW = gha_pkg::GEN_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1 = 3'd1;   // read slot table / free stack
  localparam logic [2:0] S_EV1 = 3'd2;   // evaluate, read alive position
  localparam logic [2:0] S_RD2 = 3'd3;   // read alive list at position
  localparam logic [2:0] S_RD3 = 3'd4;   // read last list entry, or write back popped slot
  localparam logic [2:0] S_EV3 = 3'd5;   // check and write back destroy
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] op_r;
  logic signed [8:0] hid_r;
  logic [15:0] hgen_r;
  logic [CW-1:0] free_depth_r, free_depth_nxt;
  logic [CW-1:0] in_use_r, in_use_nxt;
  logic [CW-1:0] alive_cnt_r, alive_cnt_nxt;
  logic [CW-1:0] pos_r;
  logic [IW-1:0] slot_r;
  logic [GW-1:0] gen_r;
  // slot generation captured for the destroy write-back
  logic [GW-1:0] st_gen_r;
  gha_pkg::result_t res_r, res_nxt;

  // memory ports
  logic st_we; logic [IW-1:0] st_wa, st_ra; logic [gha_pkg::SLOT_W-1:0] st_wd, st_rd;
  logic fs_we; logic [IW-1:0] fs_wa, fs_ra; logic [IW-1:0] fs_wd, fs_rd;
  logic al_we; logic [IW-1:0] al_wa, al_ra; logic [gha_pkg::ALIVE_W-1:0] al_wd, al_rd;
  logic ap_we; logic [IW-1:0] ap_wa, ap_ra; logic [CW-1:0] ap_wd, ap_rd;

  gha_ram #(.WIDTH(gha_pkg::SLOT_W), .DEPTH(gha_pkg::SLOTS)) u_slot (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
  gha_ram #(.WIDTH(IW), .DEPTH(gha_pkg::SLOTS)) u_free (
    .clk, .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));
  gha_ram #(.WIDTH(gha_pkg::ALIVE_W), .DEPTH(gha_pkg::SLOTS)) u_alive (
    .clk, .we(al_we), .waddr(al_wa), .wdata(al_wd), .raddr(al_ra), .rdata(al_rd));
  gha_ram #(.WIDTH(CW), .DEPTH(gha_pkg::SLOTS)) u_apos (
    .clk, .we(ap_we), .waddr(ap_wa), .wdata(ap_wd), .raddr(ap_ra), .rdata(ap_rd));

  logic [IW-1:0] hid_slot;
  logic id_in_range;
  logic [1:0] hstat;
  logic [IW-1:0] last_idx;

  assign hid_slot = hid_r[IW-1:0];
  assign id_in_range = !hid_r[8] && ({1'b0, hid_r[7:0]} < in_use_r);
  assign hstat = (id_in_range && st_rd[GW-1:0] == hgen_r) ? st_rd[GW+1:GW]
                                                         : gha_pkg::ST_INVALID;
  assign last_idx = IW'(alive_cnt_r - CW'(1));
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    free_depth_nxt = free_depth_r;
    in_use_nxt = in_use_r;
    alive_cnt_nxt = alive_cnt_r;
    res_nxt = res_r;
    st_we = 1'b0; st_wa = hid_slot; st_wd = '0; st_ra = hid_slot;
    fs_we = 1'b0; fs_wa = free_depth_r[IW-1:0]; fs_wd = hid_slot;
    fs_ra = IW'(free_depth_r - CW'(1));
    al_we = 1'b0; al_wa = alive_cnt_r[IW-1:0]; al_wd = {hid_slot, hgen_r};
    al_ra = pos_r[IW-1:0];
    ap_we = 1'b0; ap_wa = hid_slot; ap_wd = alive_cnt_r; ap_ra = hid_slot;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_RD1;
      S_RD1: begin
        // memories addressed from the captured handle and free depth
        state_nxt = S_EV1;
      end
      S_EV1: begin
        res_nxt = '0;
        unique case (op_r)
          gha_pkg::OP_RESERVE: begin
            if (free_depth_r != '0) begin
              free_depth_nxt = free_depth_r - CW'(1);
              // read the generation of the popped slot
              st_ra = fs_rd;
              res_nxt.ok = 1'b1;
              res_nxt.status = gha_pkg::ST_RESERVED;
              res_nxt.new_id = 8'(fs_rd);
            end else if (in_use_r != CW'(gha_pkg::SLOTS)) begin
              in_use_nxt = in_use_r + CW'(1);
              st_we = 1'b1; st_wa = in_use_r[IW-1:0];
              st_wd = {gha_pkg::ST_RESERVED, GW'(0)};
              res_nxt.ok = 1'b1;
              res_nxt.status = gha_pkg::ST_RESERVED;
              res_nxt.new_id = 8'(in_use_r[IW-1:0]);
            end else begin
              res_nxt.full_res = 1'b1;
            end
            res_nxt.alive_total = 9'(alive_cnt_r);
            state_nxt = (free_depth_r != '0) ? S_RD3 : S_OUT;
          end
          gha_pkg::OP_MATERIALIZE, gha_pkg::OP_DISCARD, gha_pkg::OP_DESTROY,
          gha_pkg::OP_QUERY: begin
            res_nxt.status = hstat;
            state_nxt = S_OUT;
            if (op_r == gha_pkg::OP_MATERIALIZE && hstat == gha_pkg::ST_RESERVED &&
                alive_cnt_r != CW'(gha_pkg::SLOTS)) begin
              st_we = 1'b1; st_wd = {gha_pkg::ST_ALIVE, st_rd[GW-1:0]};
              ap_we = 1'b1;
              al_we = 1'b1;
              alive_cnt_nxt = alive_cnt_r + CW'(1);
              res_nxt.ok = 1'b1;
            end else if (op_r == gha_pkg::OP_DISCARD && hstat == gha_pkg::ST_RESERVED) begin
              st_we = 1'b1; st_wd = {gha_pkg::ST_FREE, st_rd[GW-1:0] + GW'(1)};
              if (free_depth_r != CW'(gha_pkg::SLOTS)) begin
                fs_we = 1'b1;
                free_depth_nxt = free_depth_r + CW'(1);
              end
              res_nxt.ok = 1'b1;
            end else if (op_r == gha_pkg::OP_DESTROY && hstat == gha_pkg::ST_ALIVE) begin
              state_nxt = S_RD2;
            end else if (op_r == gha_pkg::OP_QUERY) begin
              res_nxt.ok = 1'b1;
            end
            res_nxt.alive_total = 9'(alive_cnt_nxt);
          end
          gha_pkg::OP_CLEAR: begin
            in_use_nxt = '0; free_depth_nxt = '0; alive_cnt_nxt = '0;
            res_nxt.ok = 1'b1;
            state_nxt = S_OUT;
          end
          default: begin
            res_nxt.alive_total = 9'(alive_cnt_r);
            state_nxt = S_OUT;
          end
        endcase
      end
      S_RD2: begin
        // ap_rd valid: read list entry at position and the last entry next
        al_ra = ap_rd[IW-1:0];
        state_nxt = S_RD3;
      end
      S_RD3: begin
        if (op_r == gha_pkg::OP_RESERVE) begin
          // generation of popped slot
          res_nxt.new_gen = 16'(st_rd[GW-1:0]);
          st_we = 1'b1; st_wa = slot_r; st_wd = {gha_pkg::ST_RESERVED, st_rd[GW-1:0]};
          state_nxt = S_OUT;
        end else begin
          al_ra = last_idx;
          state_nxt = S_EV3;
        end
      end
      S_EV3: begin
        // al_rd holds last entry; the entry at pos was captured in S_RD3 and is checked here
        state_nxt = S_OUT;
        if (pos_r < alive_cnt_r && slot_r == hid_slot && gen_r == hgen_r) begin
          if (pos_r[IW-1:0] != last_idx) begin
            al_we = 1'b1; al_wa = pos_r[IW-1:0]; al_wd = al_rd;
            ap_we = 1'b1; ap_wa = al_rd[gha_pkg::ALIVE_W-1:GW]; ap_wd = pos_r;
          end
          alive_cnt_nxt = alive_cnt_r - CW'(1);
          st_we = 1'b1; st_wd = {gha_pkg::ST_FREE, st_gen_r + GW'(1)};
          if (free_depth_r != CW'(gha_pkg::SLOTS)) begin
            fs_we = 1'b1;
            free_depth_nxt = free_depth_r + CW'(1);
          end
          res_nxt.ok = 1'b1;
        end
        res_nxt.alive_total = 9'(alive_cnt_nxt);
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_depth_r <= '0;
      in_use_r <= '0;
      alive_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      free_depth_r <= free_depth_nxt;
      in_use_r <= in_use_nxt;
      alive_cnt_r <= alive_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_IDLE && start) begin
      op_r <= in_op;
      hid_r <= in_handle_id;
      hgen_r <= in_handle_gen;
    end
    if (state_r == S_EV1) begin
      pos_r <= ap_rd;
      slot_r <= fs_rd;
      st_gen_r <= st_rd[GW-1:0];
    end
    if (state_r == S_RD2) pos_r <= ap_rd;
    if (state_r == S_RD3 && op_r != gha_pkg::OP_RESERVE) begin
      slot_r <= al_rd[gha_pkg::ALIVE_W-1:GW];
      gen_r <= al_rd[GW-1:0];
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_ok = res_r.ok;
  assign out_status = res_r.status;
  assign out_new_id = res_r.new_id;
  assign out_new_gen = res_r.new_gen;
  assign out_full_res = res_r.full_res;
  assign out_alive_total = res_r.alive_total;
endmodule

// ===== rtl/core/gha_checker.sv =====
// Port-level checker for the generational handle allocator, bound to the top.
module gha_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_ok,
  input logic [1:0] out_status,
  input logic out_full_res,
  input logic [8:0] out_alive_total
);
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted command did not raise busy");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy held after result");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> !out_ok) else $error("full reported with ok");
  a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> out_status == gha_pkg::ST_INVALID)
    else $error("full reported with a handle status");
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alive_total <= 9'd256) else $error("alive total out of range");
endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_ok, .out_status,
  .out_full_res, .out_alive_total);

// ===== bench/generational_handle_allocator_tb.sv =====
// Self-checking bench for the generational handle allocator: predicts every command result.
module generational_handle_allocator_tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_op = gha_pkg::OP_QUERY;
  logic signed [8:0] in_handle_id = '0;
  logic [15:0] in_handle_gen = '0;
  logic out_valid, out_ok, out_full_res;
  logic [1:0] out_status;
  logic [7:0] out_new_id;
  logic [15:0] out_new_gen;
  logic [8:0] out_alive_total;

  generational_handle_allocator dut (.*);

  always #5 clk = ~clk;

  // allocator image
  logic [15:0] gen_tbl [gha_pkg::SLOTS];
  logic [1:0] state_tbl [gha_pkg::SLOTS];
  int free_stk [gha_pkg::SLOTS];
  int free_depth, pool_used, alive_cnt;
  int alive_ids [gha_pkg::SLOTS];
  logic [15:0] alive_gens [gha_pkg::SLOTS];
  int alive_pos [gha_pkg::SLOTS];

  gha_pkg::result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  // handles known to the bench, for well-formed commands
  int held_ids[$];
  logic [15:0] held_gens[$];

  function automatic logic [1:0] slot_status(int id, logic [15:0] g);
    if (id < 0 || id >= pool_used) return gha_pkg::ST_INVALID;
    if (gen_tbl[id] != g) return gha_pkg::ST_INVALID;
    return state_tbl[id];
  endfunction

  function automatic void free_slot(int id);
    state_tbl[id] = gha_pkg::ST_FREE;
    gen_tbl[id] = gen_tbl[id] + 16'd1;
    if (free_depth < gha_pkg::SLOTS) begin
      free_stk[free_depth] = id;
      free_depth++;
    end
  endfunction

  function automatic gha_pkg::result_t predict_command(logic [2:0] op,
                                                       logic signed [8:0] hid,
                                                       logic [15:0] hg);
    gha_pkg::result_t r;
    int id, slot, p, last, mv;
    r = '0;
    id = hid;
    if (op == gha_pkg::OP_RESERVE) begin
      slot = -1;
      if (free_depth > 0) begin
        free_depth--;
        slot = free_stk[free_depth];
      end else if (pool_used < gha_pkg::SLOTS) begin
        slot = pool_used;
        pool_used++;
        gen_tbl[slot] = '0;
      end
      if (slot >= 0) begin
        state_tbl[slot] = gha_pkg::ST_RESERVED;
        r.ok = 1'b1;
        r.status = gha_pkg::ST_RESERVED;
        r.new_id = slot[7:0];
        r.new_gen = gen_tbl[slot];
      end else r.full_res = 1'b1;
    end else if (op >= gha_pkg::OP_MATERIALIZE && op <= gha_pkg::OP_QUERY) begin
      r.status = slot_status(id, hg);
      if (op == gha_pkg::OP_MATERIALIZE && r.status == gha_pkg::ST_RESERVED &&
          alive_cnt < gha_pkg::SLOTS) begin
        state_tbl[id] = gha_pkg::ST_ALIVE;
        alive_pos[id] = alive_cnt;
        alive_ids[alive_cnt] = id;
        alive_gens[alive_cnt] = hg;
        alive_cnt++;
        r.ok = 1'b1;
      end else if (op == gha_pkg::OP_DISCARD && r.status == gha_pkg::ST_RESERVED) begin
        free_slot(id);
        r.ok = 1'b1;
      end else if (op == gha_pkg::OP_DESTROY && r.status == gha_pkg::ST_ALIVE) begin
        p = alive_pos[id];
        if (p < alive_cnt && alive_ids[p] == id && alive_gens[p] == hg) begin
          last = alive_cnt - 1;
          if (p != last) begin
            mv = alive_ids[last];
            alive_ids[p] = mv;
            alive_gens[p] = alive_gens[last];
            alive_pos[mv] = p;
          end
          alive_cnt = last;
          free_slot(id);
          r.ok = 1'b1;
        end
      end else if (op == gha_pkg::OP_QUERY) r.ok = 1'b1;
    end else if (op == gha_pkg::OP_CLEAR) begin
      pool_used = 0;
      free_depth = 0;
      alive_cnt = 0;
      r.ok = 1'b1;
    end
    r.alive_total = alive_cnt[8:0];
    return r;
  endfunction

  task automatic gap_cycles();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_command(logic [2:0] op, logic signed [8:0] hid, logic [15:0] hg);
    gha_pkg::result_t r;
    gap_cycles();
    start <= 1'b1;
    in_op <= op;
    in_handle_id <= hid;
    in_handle_gen <= hg;
    do @(posedge clk); while (busy);
    r = predict_command(op, hid, hg);
    pending_results.insert(pending_results.size(), r);
    start <= 1'b0;
    if (op == gha_pkg::OP_RESERVE && r.ok) begin
      held_ids.insert(held_ids.size(), int'(r.new_id));
      held_gens.insert(held_gens.size(), r.new_gen);
    end
    if (op == gha_pkg::OP_CLEAR) begin
      held_ids.delete();
      held_gens.delete();
    end
    // hold off before the next command; busy is high for this cycle anyway
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    gha_pkg::result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer ok=%b status=%0d", $time, out_ok,
                 out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok) begin
          $display("%0t: ok expected %b actual %b", $time, want.ok, out_ok); errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_new_id !== want.new_id) begin
          $display("%0t: new_id expected %0d actual %0d", $time, want.new_id, out_new_id);
          errors++;
        end
        if (out_new_gen !== want.new_gen) begin
          $display("%0t: new_gen expected %0d actual %0d", $time, want.new_gen,
                   out_new_gen);
          errors++;
        end
        if (out_full_res !== want.full_res) begin
          $display("%0t: full_res expected %b actual %b", $time, want.full_res,
                   out_full_res);
          errors++;
        end
        if (out_alive_total !== want.alive_total) begin
          $display("%0t: alive_total expected %0d actual %0d", $time, want.alive_total,
                   out_alive_total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("generational_handle_allocator_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [15:0] rand_gen();
    case ($urandom_range(0, 2))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_command(gha_pkg::OP_QUERY, -9'sd1, 16'd0);
    send_command(gha_pkg::OP_DESTROY, 9'sd255, 16'hFFFF);
    send_command(gha_pkg::OP_RESERVE, 9'sd0, 16'd0);
    send_command(gha_pkg::OP_RESERVE, 9'sd0, 16'd0);
    send_command(gha_pkg::OP_QUERY, 9'sd1, 16'd0);
    send_command(gha_pkg::OP_QUERY, 9'sd1, 16'd1);
    send_command(gha_pkg::OP_MATERIALIZE, 9'sd0, 16'd0);
    send_command(gha_pkg::OP_MATERIALIZE, 9'sd0, 16'd0);
    send_command(gha_pkg::OP_MATERIALIZE, 9'sd1, 16'd0);
    send_command(gha_pkg::OP_DISCARD, 9'sd1, 16'd0);
    send_command(gha_pkg::OP_DESTROY, 9'sd0, 16'd0);
    send_command(gha_pkg::OP_QUERY, 9'sd0, 16'd1);
    send_command(gha_pkg::OP_DISCARD, 9'sd0, 16'd1);
    send_command(gha_pkg::OP_RESERVE, 9'sd0, 16'd0);
    send_command(gha_pkg::OP_DISCARD, 9'sd0, 16'd1);
    send_command(3'd6, 9'sd0, 16'd2);
    send_command(3'd7, 9'h100, 16'hFFFF);
    send_command(gha_pkg::OP_CLEAR, 9'sd0, 16'd0);
    send_command(gha_pkg::OP_QUERY, 9'sd0, 16'd1);
    drain();
  endtask

  // fill the pool to exhaustion, then hit full
  task automatic test_pool_full();
    repeat (gha_pkg::SLOTS + 2) send_command(gha_pkg::OP_RESERVE, '0, '0);
    send_command(gha_pkg::OP_MATERIALIZE, 9'sd255, 16'd0);
    send_command(gha_pkg::OP_DESTROY, 9'sd255, 16'd0);
    send_command(gha_pkg::OP_RESERVE, '0, '0);
    send_command(gha_pkg::OP_CLEAR, '0, '0);
    drain();
  endtask

  // cycle one slot through a run of generations
  task automatic test_gen_wrap();
    send_command(gha_pkg::OP_RESERVE, '0, '0);
    for (int g = 0; g < 16; g++) begin
      send_command(gha_pkg::OP_DISCARD, 9'sd0, 16'(g));
      send_command(gha_pkg::OP_RESERVE, '0, '0);
    end
    send_command(gha_pkg::OP_QUERY, 9'sd0, 16'd16);
    send_command(gha_pkg::OP_CLEAR, '0, '0);
    drain();
  endtask

  task automatic test_random(int count);
    int k, pick;
    logic [2:0] op;
    logic signed [8:0] hid;
    logic [15:0] hg;
    for (k = 0; k < count; k++) begin
      if (k == count - 200) idle_on = 1'b0;
      if (k == count / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 85 && held_ids.size() > 0) begin
        int j;
        j = $urandom_range(0, held_ids.size() - 1);
        hid = 9'(held_ids[j]);
        hg = held_gens[j];
        if ($urandom_range(0, 9) == 0) hg = hg + 16'd1;
        op = 3'($urandom_range(gha_pkg::OP_MATERIALIZE, gha_pkg::OP_QUERY));
        if ((op == gha_pkg::OP_DISCARD || op == gha_pkg::OP_DESTROY) &&
            $urandom_range(0, 1)) begin
          held_ids.delete(j);
          held_gens.delete(j);
        end
        if (held_ids.size() < 40 && $urandom_range(0, 2) == 0) op = gha_pkg::OP_RESERVE;
      end else begin
        op = (pick < 95) ? gha_pkg::OP_RESERVE : 3'($urandom_range(0, 7));
        if (op == gha_pkg::OP_CLEAR && $urandom_range(0, 3) != 0) op = gha_pkg::OP_RESERVE;
        hid = 9'($urandom);
        hg = rand_gen();
      end
      send_command(op, hid, hg);
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pool_full();
    test_gen_wrap();
    test_random(1630);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("generational_handle_allocator_tb OK");
    else $display("generational_handle_allocator_tb NOT OK");
    $finish;
  end
endmodule
